// ===== design/tsp_pkg.sv =====
// Shared types and constants for the trapezoid speed profile unit.
// Used by the controller, the datapath and the top level; depends on nothing.
package tsp_pkg;

  // Data and configuration port widths
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned FRAME_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_FRAMES     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOW_BAND       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_BAND        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_SPEED     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_GIVEN     = 3'd7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;
    logic prep1;
    logic prep2;
    logic prep3;
    logic mul;
    logic div_start;
    logic post1;
    logic post2;
    logic load_out;
  } tsp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;
  } tsp_sts_t;

endpackage

// ===== design/tsp_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Stand-alone; the caller guarantees the upper dividend part is below the divisor.
module tsp_div #(
  parameter int unsigned DW = 31,
  parameter int unsigned QW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] num_hi_i,
  input  logic [QW-1:0] num_lo_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(QW);

  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] den_q;
  logic [QW-1:0] quo_q, quo_d;
  logic [DW:0]   trial;
  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic          done_q;

  // One shift-and-subtract step; the low dividend bits shift out of the quotient word.
  always_comb begin
    trial = {rem_q, quo_q[QW-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_d = DW'(trial - {1'b0, den_q});
      quo_d = {quo_q[QW-2:0], 1'b1};
    end else begin
      rem_d = trial[DW-1:0];
      quo_d = {quo_q[QW-2:0], 1'b0};
    end
  end

  // Step counter and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (cnt_q == CW'(QW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Partial remainder, quotient and divisor
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_hi_i;
      quo_q <= num_lo_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ===== design/tsp_datapath.sv =====
// Datapath: configuration registers, profile state, band decode, two products,
// two serial dividers and the output word register. Uses tsp_pkg and tsp_div.
module tsp_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tsp_pkg::DATA_W-1:0]       cfg_data_i,
  input  logic signed [tsp_pkg::DATA_W-1:0] current_position_i,
  input  tsp_pkg::tsp_cmd_t                cmd_i,
  output tsp_pkg::tsp_sts_t                sts_o,
  output logic signed [tsp_pkg::DATA_W-1:0] speed_command_o,
  output logic                             completed_o
);

  typedef enum logic [1:0] {
    Z_END  = 2'd0,
    Z_RAMP = 2'd1,
    Z_MAX  = 2'd2
  } zone_e;

  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  // Configuration registers
  logic signed [31:0] tgt_q, max_q, min_q, slowb_q, endb_raw_q, start_q;
  logic [15:0]        rf_q;
  logic               sgiven_q;

  // Profile state
  logic               first_q, up_q;
  logic [15:0]        fc_q;

  // Per-word working registers
  logic signed [31:0] cur_q;
  logic [16:0]        fcp1_q;
  logic signed [32:0] diff_q, slow_q, rdiff_q;
  logic signed [31:0] endb_q, vmax_q, vstart_q;
  logic signed [33:0] dist_q, sum_q;
  logic [31:0]        dvm_q;
  logic               fin_q;
  zone_e              zone_q;
  logic [30:0]        dd_q;
  logic [62:0]        sprod_q;
  logic signed [50:0] rprod_q;
  logic signed [33:0] sterm_q, rterm_q, speed_q;
  logic signed [31:0] speed_out_q;
  logic               done_out_q;

  // Combinational next values
  logic signed [32:0] lim, slow_d;
  logic signed [31:0] vmax_d, endb_d, vstart_d;
  logic signed [33:0] dist_d;
  logic               fin_d;
  zone_e              zone_d;
  logic signed [50:0] rmag;
  logic [31:0]        squo, rquo;
  logic               sdone, rdone;
  logic signed [32:0] rq;
  logic signed [33:0] sterm_d, rterm_d, speed_d;
  logic signed [34:0] sneg;
  logic signed [31:0] sat_d;

  // Configuration writes and profile state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q      <= '0;
      max_q      <= '0;
      min_q      <= '0;
      rf_q       <= '0;
      slowb_q    <= '0;
      endb_raw_q <= '0;
      start_q    <= '0;
      sgiven_q   <= 1'b0;
      first_q    <= 1'b1;
      up_q       <= 1'b0;
      fc_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tsp_pkg::REG_TARGET_POSITION: tgt_q      <= cfg_data_i;
        tsp_pkg::REG_MAX_SPEED:       max_q      <= cfg_data_i;
        tsp_pkg::REG_MIN_SPEED:       min_q      <= cfg_data_i;
        tsp_pkg::REG_RAMP_FRAMES:     rf_q       <= cfg_data_i[15:0];
        tsp_pkg::REG_SLOW_BAND:       slowb_q    <= cfg_data_i;
        tsp_pkg::REG_END_BAND:        endb_raw_q <= cfg_data_i;
        tsp_pkg::REG_START_SPEED:     start_q    <= cfg_data_i;
        tsp_pkg::REG_START_GIVEN:     sgiven_q   <= cfg_data_i[0];
        default:                      tgt_q      <= tgt_q;
      endcase
      first_q <= 1'b1;
      fc_q    <= '0;
    end else if (cmd_i.accept) begin
      // The first word after a rearm latches the direction of travel.
      if (first_q) begin
        up_q    <= current_position_i < tgt_q;
        first_q <= 1'b0;
      end
      if (fc_q < rf_q) begin
        fc_q <= fc_q + 16'd1;
      end
    end
  end

  // Clamped configuration values
  always_comb begin
    vmax_d   = (max_q > min_q) ? max_q : min_q;
    endb_d   = (endb_raw_q < tgt_q) ? endb_raw_q : tgt_q;
    lim      = 33'(tgt_q) - 33'(endb_raw_q);
    slow_d   = (33'(slowb_q) < lim) ? 33'(slowb_q) : lim;
    vstart_d = sgiven_q ? start_q : min_q;
  end

  // Distance to target and completion
  always_comb begin
    dist_d = diff_q[32] ? (34'sd0 - 34'(diff_q)) : 34'(diff_q);
    fin_d  = up_q ? (diff_q <= 33'sd0) : (diff_q >= 33'sd0);
  end

  // Band decode: end band, slow-down interpolation or plain max speed
  always_comb begin
    if (dist_q < 34'(endb_q)) begin
      zone_d = Z_END;
    end else if ((slow_q > 33'sd0) && (dist_q < sum_q)) begin
      zone_d = Z_RAMP;
    end else begin
      zone_d = Z_MAX;
    end
  end

  // Magnitude of the ramp product for the unsigned divider
  assign rmag = rprod_q[50] ? (51'sd0 - rprod_q) : rprod_q;

  // Ramp quotient gets its sign back; division truncates toward zero.
  assign rq = rprod_q[50] ? (33'sd0 - $signed({1'b0, rquo})) : $signed({1'b0, rquo});

  // Slow-down and ramp-up terms
  always_comb begin
    rterm_d = 34'(vstart_q) + 34'(rq);
    case (zone_q)
      Z_END:   sterm_d = 34'(min_q);
      Z_RAMP:  sterm_d = 34'(min_q) + 34'($signed({1'b0, squo}));
      default: sterm_d = 34'(vmax_q);
    endcase
    speed_d = (sterm_q < rterm_q) ? sterm_q : rterm_q;
  end

  // Direction and saturation
  always_comb begin
    sneg = up_q ? 35'(speed_q) : (35'sd0 - 35'(speed_q));
    if (sneg > SAT_MAX) begin
      sat_d = SAT_MAX[31:0];
    end else if (sneg < SAT_MIN) begin
      sat_d = SAT_MIN[31:0];
    end else begin
      sat_d = sneg[31:0];
    end
  end

  // Working registers, advanced one step per controller command
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_q  <= current_position_i;
      fcp1_q <= {1'b0, fc_q} + 17'd1;
    end
    if (cmd_i.prep1) begin
      diff_q   <= 33'(tgt_q) - 33'(cur_q);
      endb_q   <= endb_d;
      slow_q   <= slow_d;
      vmax_q   <= vmax_d;
      vstart_q <= vstart_d;
    end
    if (cmd_i.prep2) begin
      dist_q  <= dist_d;
      sum_q   <= 34'(slow_q) + 34'(endb_q);
      dvm_q   <= 32'(33'(vmax_q) - 33'(min_q));
      rdiff_q <= 33'(vmax_q) - 33'(vstart_q);
      fin_q   <= fin_d;
    end
    if (cmd_i.prep3) begin
      zone_q <= zone_d;
      dd_q   <= 31'(dist_q - 34'(endb_q));
    end
    if (cmd_i.mul) begin
      sprod_q <= 63'(dvm_q) * 63'(dd_q);
      rprod_q <= 51'(rdiff_q) * 51'($signed({1'b0, fcp1_q}));
    end
    if (cmd_i.post1) begin
      sterm_q <= sterm_d;
      rterm_q <= rterm_d;
    end
    if (cmd_i.post2) begin
      speed_q <= speed_d;
    end
    if (cmd_i.load_out) begin
      speed_out_q <= sat_d;
      done_out_q  <= fin_q;
    end
  end

  // Slow-down interpolation divider: (vmax - vmin) * depth / band width
  tsp_div #(
    .DW (31),
    .QW (32)
  ) u_slow_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_hi_i (sprod_q[62:32]),
    .num_lo_i (sprod_q[31:0]),
    .den_i    (slow_q[30:0]),
    .quo_o    (squo),
    .done_o   (sdone)
  );

  // Ramp-up divider: (vmax - vstart) * (frame + 1) / (ramp_frames + 1)
  tsp_div #(
    .DW (17),
    .QW (32)
  ) u_ramp_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .num_hi_i (rmag[48:32]),
    .num_lo_i (rmag[31:0]),
    .den_i    ({1'b0, rf_q} + 17'd1),
    .quo_o    (rquo),
    .done_o   (rdone)
  );

  assign sts_o.div_done  = sdone & rdone;
  assign speed_command_o = speed_out_q;
  assign completed_o     = done_out_q;

endmodule

// ===== design/tsp_ctrl.sv =====
// Controller: sequences one word through the datapath and owns the handshakes.
// Uses tsp_pkg for the command and status structs.
module tsp_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  tsp_pkg::tsp_sts_t sts_i,
  output tsp_pkg::tsp_cmd_t cmd_o
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_PREP1 = 10'b00_0000_0010,
    S_PREP2 = 10'b00_0000_0100,
    S_PREP3 = 10'b00_0000_1000,
    S_MUL   = 10'b00_0001_0000,
    S_DIVS  = 10'b00_0010_0000,
    S_DIVW  = 10'b00_0100_0000,
    S_POST1 = 10'b00_1000_0000,
    S_POST2 = 10'b01_0000_0000,
    S_FIN   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP1;
        end
      end
      S_PREP1: begin
        cmd_o.prep1 = 1'b1;
        state_d     = S_PREP2;
      end
      S_PREP2: begin
        cmd_o.prep2 = 1'b1;
        state_d     = S_PREP3;
      end
      S_PREP3: begin
        cmd_o.prep3 = 1'b1;
        state_d     = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DIVS;
      end
      S_DIVS: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIVW;
      end
      S_DIVW: begin
        if (sts_i.div_done) begin
          state_d = S_POST1;
        end
      end
      S_POST1: begin
        cmd_o.post1 = 1'b1;
        state_d     = S_POST2;
      end
      S_POST2: begin
        cmd_o.post2 = 1'b1;
        state_d     = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // A new output word only appears from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("output word raised outside the final state");

  // An untaken output word is never overwritten.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("output register loaded while still full");

  // Starting the dividers clears their done status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVS) |=> !sts_i.div_done)
    else $error("divider done not cleared by start");

endmodule

// ===== design/trapezoid_speed_profile_unit.sv =====
// Trapezoid speed profile unit: one speed command word per position word.
// Words are taken one at a time: a new word is accepted only once the last one has
// been through the two 32-step serial dividers, run in parallel, and loaded out.
// The input is accepted while a finished output word still waits to be taken.
// Reset (rst_ni low, asynchronous) clears the configuration registers, the frame
// count and the handshake state and rearms the direction latch; configuration
// writes also rearm it and clear the frame count.
module trapezoid_speed_profile_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tsp_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tsp_pkg::DATA_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [tsp_pkg::DATA_W-1:0] current_position_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [tsp_pkg::DATA_W-1:0] speed_command_o,
  output logic                              completed_o
);

  tsp_pkg::tsp_cmd_t cmd;
  tsp_pkg::tsp_sts_t sts;

  // Sequencer
  tsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and state
  tsp_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .current_position_i (current_position_i),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .speed_command_o    (speed_command_o),
    .completed_o        (completed_o)
  );

endmodule

// ===== test/tb_trapezoid_speed_profile_unit.sv =====
// Self-checking testbench for trapezoid_speed_profile_unit: directed and random position words
// checked against an in-bench model of the speed profile. Depends on tsp_pkg and the RTL.
module tb_trapezoid_speed_profile_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import tsp_pkg::*;

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam int     GAP_MAX  = 17;
  localparam int     N_ITEMS  = 2000;

  typedef struct packed {
    logic signed [DATA_W-1:0] speed;
    logic                     completed;
  } speed_word_t;

  logic                     clk_i;
  logic                     rst_ni             = 1'b0;
  logic                     cfg_we_i           = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx_i          = REG_TARGET_POSITION;
  logic [DATA_W-1:0]        cfg_data_i         = '0;
  logic                     in_valid_i         = 1'b0;
  logic                     in_ready_o;
  logic signed [DATA_W-1:0] current_position_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i        = 1'b0;
  logic signed [DATA_W-1:0] speed_command_o;
  logic                     completed_o;

  // Expected speed words in order of acceptance, and run bookkeeping.
  speed_word_t expected_words[$];
  int          mismatches    = 0;
  int          items_sent    = 0;
  int          stall_request = 0;
  bit          send_idle     = 1'b1;
  bit          recv_idle     = 1'b1;

  // Shadow copy of the profile registers and state.
  longint             prof_target, prof_max, prof_min, prof_slow, prof_end, prof_start;
  logic [FRAME_W-1:0] prof_ramp, prof_frame;
  logic               prof_start_given, prof_first, prof_up;

  trapezoid_speed_profile_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .current_position_i (current_position_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .speed_command_o    (speed_command_o),
    .completed_o        (completed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // A register write updates the shadow copy and rearms the direction latch.
  function automatic void update_profile_reg(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [DATA_W-1:0] data);
    case (idx)
      REG_TARGET_POSITION: prof_target      = $signed(data);
      REG_MAX_SPEED:       prof_max         = $signed(data);
      REG_MIN_SPEED:       prof_min         = $signed(data);
      REG_RAMP_FRAMES:     prof_ramp        = data[FRAME_W-1:0];
      REG_SLOW_BAND:       prof_slow        = $signed(data);
      REG_END_BAND:        prof_end         = $signed(data);
      REG_START_SPEED:     prof_start       = $signed(data);
      REG_START_GIVEN:     prof_start_given = data[0];
      default: ;
    endcase
    prof_first = 1'b1;
    prof_frame = '0;
  endfunction

  // Speed command and completed flag for one position; advances the frame count.
  function automatic speed_word_t predict_speed(input logic signed [DATA_W-1:0] pos);
    longint      cur, vmax, endb, lim, slow, vstart, dist_abs, slow_term, ramp_term, speed;
    speed_word_t w;
    cur    = pos;
    vmax   = (prof_max > prof_min) ? prof_max : prof_min;
    endb   = (prof_end < prof_target) ? prof_end : prof_target;
    lim    = prof_target - prof_end;
    slow   = (prof_slow < lim) ? prof_slow : lim;
    vstart = prof_start_given ? prof_start : prof_min;
    if (prof_first) begin
      prof_up    = cur < prof_target;
      prof_first = 1'b0;
    end
    dist_abs = prof_target - cur;
    if (dist_abs < 0) dist_abs = -dist_abs;
    // Slow-down term: min speed in the end band, linear inside the slow band.
    if (dist_abs < endb) begin
      slow_term = prof_min;
    end else if (slow > 0 && dist_abs < slow + endb) begin
      slow_term = prof_min + (vmax - prof_min) * (dist_abs - endb) / slow;
    end else begin
      slow_term = vmax;
    end
    ramp_term = vstart + (vmax - vstart) * (longint'(prof_frame) + 1)
                / (longint'(prof_ramp) + 1);
    speed = (slow_term < ramp_term) ? slow_term : ramp_term;
    if (!prof_up) speed = -speed;
    if (speed > WORD_MAX) speed = WORD_MAX;
    if (speed < WORD_MIN) speed = WORD_MIN;
    if (prof_frame < prof_ramp) prof_frame++;
    w.speed     = speed[DATA_W-1:0];
    w.completed = prof_up ? (cur >= prof_target) : (cur <= prof_target);
    return w;
  endfunction

  // Random word that often lands on a corner value.
  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] clip_position(input longint v);
    if (v > WORD_MAX) v = WORD_MAX;
    if (v < WORD_MIN) v = WORD_MIN;
    return v[DATA_W-1:0];
  endfunction

  // Offer one position word after a random gap and predict its result on acceptance.
  task automatic send_position(input logic [DATA_W-1:0] pos);
    int gap;
    gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    current_position_i <= pos;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words.push_back(predict_speed(pos));
    items_sent++;
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_words.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    update_profile_reg(idx, data);
  endtask

  task automatic apply_profile(input logic [DATA_W-1:0] target, input logic [DATA_W-1:0] vmax,
                               input logic [DATA_W-1:0] vmin, input logic [DATA_W-1:0] ramp,
                               input logic [DATA_W-1:0] slow, input logic [DATA_W-1:0] endb,
                               input logic [DATA_W-1:0] vstart, input logic [DATA_W-1:0] given);
    drain_results();
    write_reg(REG_TARGET_POSITION, target);
    write_reg(REG_MAX_SPEED,       vmax);
    write_reg(REG_MIN_SPEED,       vmin);
    write_reg(REG_RAMP_FRAMES,     ramp);
    write_reg(REG_SLOW_BAND,       slow);
    write_reg(REG_END_BAND,        endb);
    write_reg(REG_START_SPEED,     vstart);
    write_reg(REG_START_GIVEN,     given);
  endtask

  // All registers at zero: the speed stays zero, only the completed flag moves.
  task automatic test_reset_values();
    send_position(32'h0000_0000);
    send_position(32'h7FFF_FFFF);
    send_position(32'h8000_0000);
  endtask

  // Hand-picked profiles: a full trapezoid, clamps, saturation and empty bands.
  task automatic test_directed_profiles();
    // Moving up through ramp, slow-down band, end band and past the target.
    apply_profile(32'h0010_0000, 32'h0004_0000, 32'h0000_8000, 32'd3,
                  32'h0006_0000, 32'h0001_0000, 32'h0001_0000, 32'd1);
    send_position(32'h0000_0000);
    send_position(32'h0002_0000);
    send_position(32'h0004_0000);
    send_position(32'h0008_0000);
    send_position(32'h000C_0000);
    send_position(32'h000F_8000);
    send_position(32'h0010_0000);
    send_position(32'h0011_0000);
    // Moving down; max below min, end band and slow band clamped, no ramp.
    apply_profile(32'hFFFB_0000, 32'h0000_1000, 32'h0000_4000, 32'd0,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0);
    send_position(32'h7FFF_FFFF);
    send_position(32'h0000_0000);
    send_position(32'hFFFB_0000);
    send_position(32'h8000_0000);
    // Negated most negative speed saturates; longest ramp, negative end band.
    apply_profile(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0000_FFFF,
                  32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
    send_position(32'h8000_0000);
    send_position(32'h7FFF_FFFF);
    send_position(32'h0000_0000);
    // Zero slow band, negative min speed, full-range distance.
    apply_profile(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1,
                  32'h0000_0000, 32'hFFFF_FFFB, 32'h0000_0000, 32'd1);
    send_position(32'h8000_0000);
    send_position(32'h7FFF_FFFE);
    send_position(32'h7FFF_FFFF);
  endtask

  // The receiver holds off for a long stretch while words keep coming, then the
  // sender waits for the pipeline to empty before going on.
  task automatic test_output_backpressure();
    int k;
    apply_profile(32'h0020_0000, 32'h0003_0000, 32'h0000_4000, 32'd5,
                  32'h0008_0000, 32'h0001_0000, 32'h0000_0000, 32'd0);
    send_idle     = 1'b0;
    recv_idle     = 1'b0;
    stall_request = 300;
    for (k = 0; k < 12; k++) send_position(k * 32'h0002_0000);
    drain_results();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (k = 12; k < 18; k++) send_position(k * 32'h0002_0000);
    drain_results();
  endtask

  // Random profiles, mostly an approach to the target with small jitter,
  // the rest corner-heavy noise and partial register rewrites.
  task automatic test_random_profiles();
    longint           tgt, p0, off, pos;
    logic [DATA_W-1:0] tw, vmin, vmax, ramp;
    int               n, k;
    bit               noise;
    while (items_sent < N_ITEMS) begin
      send_idle = $urandom_range(0, 3) != 0;
      recv_idle = $urandom_range(0, 3) != 0;
      noise     = $urandom_range(0, 3) == 0;
      ramp      = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 32'hFFFF : $urandom)
                                              : $urandom_range(0, 15);
      drain_results();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) write_reg(CFG_IDX_W'($urandom_range(0, 7)), rand_word());
      end else if (noise) begin
        apply_profile(rand_word(), rand_word(), rand_word(), ramp, rand_word(), rand_word(),
                      rand_word(), $urandom_range(0, 1));
      end else begin
        tw   = $urandom;
        tw   = $urandom_range(0, 5) == 0 ? rand_word() : {{8{tw[23]}}, tw[23:0]};
        vmin = $urandom_range(0, 32'h0004_0000);
        vmax = ($urandom_range(0, 7) == 0) ? vmin - $urandom_range(0, 32'h0001_0000)
                                           : vmin + $urandom_range(0, 32'h0010_0000);
        apply_profile(tw, vmax, vmin, ramp, $urandom_range(0, 32'h0040_0000),
                      $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0008_0000),
                      $urandom_range(0, 1));
      end
      n   = $urandom_range(8, 50);
      tgt = prof_target;
      off = longint'($urandom_range(0, 32'h0080_0000));
      p0  = $urandom_range(0, 1) ? tgt + off : tgt - off;
      for (k = 0; k < n; k++) begin
        if (noise) begin
          pos = $signed(rand_word());
        end else begin
          pos = p0 + (tgt - p0) * k / (n - 4) + longint'($urandom_range(0, 4096)) - 2048;
        end
        send_position(clip_position(pos));
      end
    end
    drain_results();
  endtask

  // Result side: random stall per word, then compare against the oldest expectation.
  initial begin
    int          stall;
    speed_word_t exp_w;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (stall_request > 0) begin
        stall         = stall_request;
        stall_request = 0;
      end
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, speed_command %h completed %b", $time,
                 speed_command_o, completed_o);
      end else begin
        exp_w = expected_words.pop_front();
        if (speed_command_o !== exp_w.speed) begin
          mismatches++;
          $display("%0t: speed_command mismatch, expected %h, actual %h", $time,
                   exp_w.speed, speed_command_o);
        end
        if (completed_o !== exp_w.completed) begin
          mismatches++;
          $display("%0t: completed mismatch, expected %b, actual %b", $time,
                   exp_w.completed, completed_o);
        end
      end
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #6_000_000;
    $display("** trapezoid_speed_profile_unit: FAILED **");
    $finish;
  end

  initial begin
    prof_target      = 0;
    prof_max         = 0;
    prof_min         = 0;
    prof_slow        = 0;
    prof_end         = 0;
    prof_start       = 0;
    prof_ramp        = '0;
    prof_frame       = '0;
    prof_start_given = 1'b0;
    prof_first       = 1'b1;
    prof_up          = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_values();
    test_directed_profiles();
    test_output_backpressure();
    test_random_profiles();
    // Watch for stray words for a little longer than one pass through the block.
    drain_results();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** trapezoid_speed_profile_unit: PASSED **");
    end else begin
      $display("** trapezoid_speed_profile_unit: FAILED **");
    end
    $finish;
  end

endmodule
